@@ hdl/tcpf_pkg.sv @@
package tcpf_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int ID_W     = 16;
  localparam int WORK_W   = 8;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queued request.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] work;
    logic [KIND_W-1:0] kind;
    logic              urgent;
  } entry_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    logic   pop_urgent;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ hdl/tcpf_if.sv @@
interface tcpf_in_if;
  import tcpf_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   entry_id;
  logic [WORK_W-1:0] entry_work;
  logic [KIND_W-1:0] entry_kind;
  logic              entry_urgent;

  modport source (output valid, op, entry_id, entry_work, entry_kind, entry_urgent,
                  input ready);
  modport sink   (input valid, op, entry_id, entry_work, entry_kind, entry_urgent,
                  output ready);
endinterface

interface tcpf_out_if;
  import tcpf_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic [WORK_W-1:0]   out_work;
  logic [KIND_W-1:0]   out_kind;
  logic                out_urgent;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, status, out_id, out_work, out_kind, out_urgent, fill_level,
                  input ready);
  modport sink   (input valid, status, out_id, out_work, out_kind, out_urgent, fill_level,
                  output ready);
endinterface

@@ hdl/two_class_priority_fifo_core.sv @@
// Channel | Dir | Beat contents
// in_ch   | in  | op, entry_id, entry_work, entry_kind, entry_urgent
// out_ch  | out | status, out_id, out_work, out_kind, out_urgent, fill_level
//
// Each accepted input beat yields one output beat in the next cycle; one beat per
// cycle unless the output stalls. The result sits in an output register, and a new
// beat is taken whenever that register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// A stalled output holds the queue still; nothing is dropped.
module two_class_priority_fifo_core #(
  parameter int QUEUE_DEPTH = tcpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcpf_in_if.sink     in_ch,
  tcpf_out_if.source  out_ch
);
  import tcpf_pkg::*;

  // Counts reach QUEUE_DEPTH itself, so they need one extra code.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // The queue is a row of cells ordered by age: cell 0 holds the oldest entry.
  // A push lands in the first empty cell. A pop removes either cell 0 or the
  // oldest urgent cell, and every cell behind the removed one copies its right
  // neighbor, which closes the gap while keeping arrival order. Each cell tracks
  // how many urgent entries sit at or before it, so finding the oldest urgent
  // entry and deciding who shifts are both local decisions.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] urg_cnt_r, urg_cnt_nxt;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  entry_t           result_r, result_nxt;
  logic [FILL_W-1:0] fill_r;

  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] new_rank;

  logic [QUEUE_DEPTH:0]   valid_vec;
  entry_t                 ent_arr  [QUEUE_DEPTH+1];
  logic [CNT_W-1:0]       rank_arr [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] hit_vec;
  entry_t                 urg_pick;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    ctrl.new_entry.id     = in_ch.entry_id;
    ctrl.new_entry.work   = in_ch.entry_work;
    ctrl.new_entry.kind   = in_ch.entry_kind;
    ctrl.new_entry.urgent = in_ch.entry_urgent;
    ctrl.push_en    = accept && (in_ch.op == OP_PUSH) && !full;
    ctrl.pop_en     = accept && (in_ch.op == OP_POP) && !empty;
    ctrl.pop_urgent = (urg_cnt_r != '0);
    // The new tail follows every queued urgent entry.
    new_rank = urg_cnt_r + CNT_W'(in_ch.entry_urgent);
  end

  // Past the last cell the chain reads as empty.
  assign valid_vec[QUEUE_DEPTH] = 1'b0;
  assign ent_arr[QUEUE_DEPTH]   = '0;
  assign rank_arr[QUEUE_DEPTH]  = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic left_v;
    if (g == 0) begin : g_first
      assign left_v = 1'b1;
    end else begin : g_rest
      assign left_v = valid_vec[g-1];
    end

    tcpf_cell #(
      .RANK_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_rank    (new_rank),
      .left_valid  (left_v),
      .right_valid (valid_vec[g+1]),
      .right_entry (ent_arr[g+1]),
      .right_rank  (rank_arr[g+1]),
      .valid       (valid_vec[g]),
      .entry       (ent_arr[g]),
      .rank        (rank_arr[g]),
      .hit         (hit_vec[g])
    );
  end

  // Exactly one cell hits while an urgent entry is queued; a one-hot AND-OR mux.
  always_comb begin
    urg_pick = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      urg_pick = urg_pick | (hit_vec[i] ? ent_arr[i] : '0);
    end
  end

  always_comb begin
    count_nxt   = count_r;
    urg_cnt_nxt = urg_cnt_r;
    status_nxt  = ST_DONE;
    result_nxt  = '0;
    if (in_ch.op == OP_PUSH) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt   = count_r + CNT_W'(1);
        urg_cnt_nxt = new_rank;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        if (ctrl.pop_urgent) begin
          result_nxt  = urg_pick;
          urg_cnt_nxt = urg_cnt_r - CNT_W'(1);
        end else begin
          result_nxt = ent_arr[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      urg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        urg_cnt_r   <= urg_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      result_r <= result_nxt;
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.out_id     = result_r.id;
  assign out_ch.out_work   = result_r.work;
  assign out_ch.out_kind   = result_r.kind;
  assign out_ch.out_urgent = result_r.urgent;
  assign out_ch.fill_level = fill_r;

  // Occupied cells always form an unbroken run from cell 0.
  a_cells_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec[QUEUE_DEPTH-1:0]) == count_r &&
    (count_r == '0 || valid_vec[0]))
    else $error("cell occupancy disagrees with entry count");

  a_urgent_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    urg_cnt_r <= count_r)
    else $error("urgent count exceeds entry count");

  a_one_urgent_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (urg_cnt_r != '0) |-> $onehot(hit_vec))
    else $error("oldest urgent entry not unique");

  a_no_hit_without_urgent: assert property (@(posedge clk) disable iff (!rst_n)
    (urg_cnt_r == '0) |-> (hit_vec == '0))
    else $error("urgent hit with no urgent entry queued");

endmodule

@@ hdl/tcpf_cell.sv @@
module tcpf_cell #(
  parameter int RANK_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcpf_pkg::cell_ctrl_t   ctrl,
  input  logic [RANK_W-1:0]      new_rank,
  input  logic                   left_valid,
  input  logic                   right_valid,
  input  tcpf_pkg::entry_t       right_entry,
  input  logic [RANK_W-1:0]      right_rank,
  output logic                   valid,
  output tcpf_pkg::entry_t       entry,
  output logic [RANK_W-1:0]      rank,
  output logic                   hit
);
  import tcpf_pkg::*;

  // rank_r counts the urgent entries in this cell and all older cells.
  // It is zero in empty cells.
  logic              valid_r, valid_nxt;
  entry_t            entry_r, entry_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              is_tail;
  logic              shift;

  always_comb begin
    is_tail   = !valid_r && left_valid;
    // On an urgent pop only the removed cell and the cells behind it move.
    shift     = ctrl.pop_en && (!ctrl.pop_urgent || rank_r != '0);
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    rank_nxt  = rank_r;
    if (ctrl.push_en && is_tail) begin
      valid_nxt = 1'b1;
      entry_nxt = ctrl.new_entry;
      rank_nxt  = new_rank;
    end else if (shift) begin
      valid_nxt = right_valid;
      entry_nxt = right_entry;
      if (ctrl.pop_urgent && right_valid) begin
        rank_nxt = right_rank - RANK_W'(1);
      end else begin
        rank_nxt = right_rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign rank  = rank_r;
  assign hit   = valid_r && entry_r.urgent && (rank_r == RANK_W'(1));

endmodule
